// File: sv/doc_tag_stream_splitter_macros.svh
// assertion macros for the document splitter checker
// no dependencies; included by the checker file only
`ifndef DOC_TAG_STREAM_SPLITTER_MACROS_SVH
`define DOC_TAG_STREAM_SPLITTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define DTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/dts_pkg.sv
// shared constants, types and character helpers for the document splitter
// no dependencies
`default_nettype none

package dts_pkg;

    localparam int TAG_BUF_DEPTH = 64;
    localparam int CHAR_W        = 21;
    localparam int CNT_W         = 32;
    localparam int FILL_W        = $clog2(TAG_BUF_DEPTH + 1);
    localparam int IDX_W         = $clog2(TAG_BUF_DEPTH);
    localparam int NAME_W        = 4;

    localparam logic [NAME_W-1:0] SHORT_LEN = NAME_W'(3);
    localparam logic [NAME_W-1:0] LONG_LEN  = NAME_W'(8);
    localparam logic [NAME_W-1:0] NAME_CAP  = NAME_W'(9);

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t CH_LT    = char_t'(8'h3C);
    localparam char_t CH_GT    = char_t'(8'h3E);
    localparam char_t CH_SLASH = char_t'(8'h2F);
    localparam char_t CH_SPACE = char_t'(8'h20);

    typedef struct packed {
        logic accept;
        logic start_tag;
        logic store;
        logic open_name;
        logic close_init;
        logic close_name;
        logic set_long;
        logic restart;
        logic end_clear;
        logic emit_in;
        logic emit_last;
        logic emit_marker;
        logic dump_start;
        logic dump_read;
        logic dump_emit;
    } cmd_t;

    typedef struct packed {
        logic is_space;
        logic is_alnum;
        logic is_lt;
        logic is_gt;
        logic is_slash;
        logic open_doc;
        logic open_long;
        logic close_hit;
        logic dump_last;
        logic out_free;
    } sts_t;

    // letters of DOCUMENT; the first three spell DOC
    function automatic char_t long_name_char(input logic [NAME_W-1:0] pos);
        char_t c;
        case (pos)
            NAME_W'(0): c = char_t'(8'h44);
            NAME_W'(1): c = char_t'(8'h4F);
            NAME_W'(2): c = char_t'(8'h43);
            NAME_W'(3): c = char_t'(8'h55);
            NAME_W'(4): c = char_t'(8'h4D);
            NAME_W'(5): c = char_t'(8'h45);
            NAME_W'(6): c = char_t'(8'h4E);
            NAME_W'(7): c = char_t'(8'h54);
            default:    c = '0;
        endcase
        return c;
    endfunction

    function automatic char_t to_upper(input char_t c);
        char_t u;
        if (c >= char_t'(8'h61) && c <= char_t'(8'h7A))
        begin
            u = c - char_t'(8'h20);
        end
        else
        begin
            u = c;
        end
        return u;
    endfunction

    function automatic logic is_space(input char_t c);
        return (c == CH_SPACE) || (c >= char_t'(9) && c <= char_t'(13));
    endfunction

    function automatic logic is_alnum(input char_t c);
        return (c >= char_t'(8'h30) && c <= char_t'(8'h39))
            || (c >= char_t'(8'h41) && c <= char_t'(8'h5A))
            || (c >= char_t'(8'h61) && c <= char_t'(8'h7A));
    endfunction

endpackage

`default_nettype wire

// File: sv/dts_stream_if.sv
// valid/ready channel interfaces for the input and result streams
// depends on dts_pkg for field widths
`default_nettype none

interface dts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [dts_pkg::CHAR_W-1:0]  in_char;

    modport source  (output valid, output op, output in_char, input ready);
    modport sink    (input valid, input op, input in_char, output ready);
    modport monitor (input valid, input op, input in_char, input ready);
endinterface

interface dts_out_if;
    logic                        valid;
    logic                        ready;
    logic [dts_pkg::CHAR_W-1:0]  out_char;
    logic                        char_valid;
    logic [dts_pkg::CNT_W-1:0]   doc_offset;
    logic                        first_of_doc;
    logic                        last;
    logic                        truncated;
    logic                        tag_clipped;

    modport source  (output valid, output out_char, output char_valid, output doc_offset,
                     output first_of_doc, output last, output truncated, output tag_clipped,
                     input ready);
    modport sink    (input valid, input out_char, input char_valid, input doc_offset,
                     input first_of_doc, input last, input truncated, input tag_clipped,
                     output ready);
    modport monitor (input valid, input out_char, input char_valid, input doc_offset,
                     input first_of_doc, input last, input truncated, input tag_clipped,
                     input ready);
endinterface

`default_nettype wire

// File: sv/dts_datapath.sv
// datapath: counters, tag buffer memory, name matching and output register
// depends on dts_pkg; driven by dts_ctrl commands
`default_nettype none

module dts_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dts_pkg::cmd_t              cmd,
    input  wire dts_pkg::char_t             in_char,
    input  wire logic                       out_ready,
    output dts_pkg::sts_t                   sts,
    output logic                            out_valid,
    output dts_pkg::char_t                  out_char,
    output logic                            char_valid,
    output logic [dts_pkg::CNT_W-1:0]       doc_offset,
    output logic                            first_of_doc,
    output logic                            last,
    output logic                            truncated,
    output logic                            tag_clipped
);
    import dts_pkg::*;

    char_t                tag_mem [TAG_BUF_DEPTH];

    logic [CNT_W-1:0]     char_count_reg,   char_count_next;
    logic [CNT_W-1:0]     search_start_reg, search_start_next;
    logic [FILL_W-1:0]    tag_fill_reg,     tag_fill_next;
    logic [NAME_W-1:0]    name_pos_reg,     name_pos_next;
    logic [1:0]           match_flags_reg,  match_flags_next;
    logic                 open_is_long_reg, open_is_long_next;
    logic                 close_match_reg,  close_match_next;
    logic                 clip_reg,         clip_next;
    logic [IDX_W-1:0]     dump_idx_reg,     dump_idx_next;
    char_t                rd_data_reg;
    logic                 out_valid_reg,    out_valid_next;
    char_t                out_char_reg;
    logic                 char_valid_reg;
    logic [CNT_W-1:0]     doc_offset_reg;
    logic                 first_reg;
    logic                 last_reg;
    logic                 trunc_reg;
    logic                 clipped_reg;

    char_t                upper_char;
    logic                 pos_hit;
    logic [NAME_W-1:0]    close_len;
    logic                 buf_room;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic                 out_load;

    assign upper_char = to_upper(in_char);
    assign pos_hit    = (upper_char == long_name_char(name_pos_reg));
    assign close_len  = open_is_long_reg ? LONG_LEN : SHORT_LEN;
    assign buf_room   = (tag_fill_reg < FILL_W'(TAG_BUF_DEPTH));
    assign mem_we     = cmd.start_tag || (cmd.store && buf_room);
    assign mem_waddr  = cmd.start_tag ? '0 : tag_fill_reg[IDX_W-1:0];
    assign out_load   = cmd.emit_in || cmd.emit_marker || cmd.dump_emit;

    always_comb
    begin
        sts.is_space  = is_space(in_char);
        sts.is_alnum  = is_alnum(in_char);
        sts.is_lt     = (in_char == CH_LT);
        sts.is_gt     = (in_char == CH_GT);
        sts.is_slash  = (in_char == CH_SLASH);
        sts.open_doc  = match_flags_reg[0] && (name_pos_reg == SHORT_LEN);
        sts.open_long = match_flags_reg[1] && (name_pos_reg == LONG_LEN);
        sts.close_hit = close_match_reg && (name_pos_reg == close_len);
        sts.dump_last = ((FILL_W'(dump_idx_reg) + FILL_W'(1)) == tag_fill_reg);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        char_count_next   = cmd.accept ? char_count_reg + CNT_W'(1) : char_count_reg;
        search_start_next = cmd.restart ? char_count_reg + CNT_W'(1) : search_start_reg;

        tag_fill_next = tag_fill_reg;
        clip_next     = clip_reg;
        if (cmd.start_tag)
        begin
            tag_fill_next = FILL_W'(1);
            clip_next     = 1'b0;
        end
        else if (cmd.store)
        begin
            if (buf_room)
            begin
                tag_fill_next = tag_fill_reg + FILL_W'(1);
            end
            else
            begin
                clip_next = 1'b1;
            end
        end
        else if (cmd.end_clear)
        begin
            tag_fill_next = '0;
            clip_next     = 1'b0;
        end

        name_pos_next = name_pos_reg;
        if (cmd.start_tag || cmd.close_init)
        begin
            name_pos_next = '0;
        end
        else if ((cmd.open_name || cmd.close_name) && (name_pos_reg < NAME_CAP))
        begin
            name_pos_next = name_pos_reg + NAME_W'(1);
        end

        match_flags_next = match_flags_reg;
        if (cmd.start_tag)
        begin
            match_flags_next = 2'b11;
        end
        else if (cmd.open_name)
        begin
            if (!((name_pos_reg < SHORT_LEN) && pos_hit))
            begin
                match_flags_next[0] = 1'b0;
            end
            if (!((name_pos_reg < LONG_LEN) && pos_hit))
            begin
                match_flags_next[1] = 1'b0;
            end
        end

        close_match_next = close_match_reg;
        if (cmd.close_init)
        begin
            close_match_next = 1'b1;
        end
        else if (cmd.close_name && !((name_pos_reg < close_len) && pos_hit))
        begin
            close_match_next = 1'b0;
        end

        open_is_long_next = cmd.set_long ? sts.open_long : open_is_long_reg;

        dump_idx_next = dump_idx_reg;
        if (cmd.dump_start)
        begin
            dump_idx_next = '0;
        end
        else if (cmd.dump_emit)
        begin
            dump_idx_next = dump_idx_reg + IDX_W'(1);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= '0;
            search_start_reg <= '0;
            tag_fill_reg     <= '0;
            name_pos_reg     <= '0;
            match_flags_reg  <= 2'b11;
            open_is_long_reg <= 1'b0;
            close_match_reg  <= 1'b1;
            clip_reg         <= 1'b0;
            dump_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            char_count_reg   <= char_count_next;
            search_start_reg <= search_start_next;
            tag_fill_reg     <= tag_fill_next;
            name_pos_reg     <= name_pos_next;
            match_flags_reg  <= match_flags_next;
            open_is_long_reg <= open_is_long_next;
            close_match_reg  <= close_match_next;
            clip_reg         <= clip_next;
            dump_idx_reg     <= dump_idx_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // tag buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_waddr] <= in_char;
        end
        if (cmd.dump_read)
        begin
            rd_data_reg <= tag_mem[dump_idx_reg];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg   <= cmd.emit_in ? in_char : (cmd.dump_emit ? rd_data_reg : '0);
            char_valid_reg <= !cmd.emit_marker;
            doc_offset_reg <= search_start_reg;
            first_reg      <= cmd.dump_emit && (dump_idx_reg == '0);
            last_reg       <= cmd.emit_marker || (cmd.emit_in && cmd.emit_last);
            trunc_reg      <= cmd.emit_marker;
            clipped_reg    <= clip_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign char_valid   = char_valid_reg;
    assign doc_offset   = doc_offset_reg;
    assign first_of_doc = first_reg;
    assign last         = last_reg;
    assign truncated    = trunc_reg;
    assign tag_clipped  = clipped_reg;

endmodule

`default_nettype wire

// File: sv/dts_ctrl.sv
// controller: tag parsing state machine and tag dump sequencing
// depends on dts_pkg; drives dts_datapath through cmd_t
`default_nettype none

module dts_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic           op,
    input  wire dts_pkg::sts_t  sts,
    output logic                in_ready,
    output dts_pkg::cmd_t       cmd
);
    import dts_pkg::*;

    localparam logic [3:0] PH_SEEK    = 4'd0;
    localparam logic [3:0] PH_OWS     = 4'd1;
    localparam logic [3:0] PH_ONAME   = 4'd2;
    localparam logic [3:0] PH_OREST   = 4'd3;
    localparam logic [3:0] PH_CSEEK   = 4'd4;
    localparam logic [3:0] PH_CSLASH  = 4'd5;
    localparam logic [3:0] PH_CSKIP   = 4'd6;
    localparam logic [3:0] PH_CWS     = 4'd7;
    localparam logic [3:0] PH_CNAME   = 4'd8;
    localparam logic [3:0] PH_CREST   = 4'd9;
    localparam logic [3:0] ST_DUMP_RD = 4'd10;
    localparam logic [3:0] ST_DUMP_WR = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       in_dump;
    logic       accept;

    assign in_dump  = (state_reg inside {ST_DUMP_RD, ST_DUMP_WR});
    assign in_ready = sts.out_free && !in_dump;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.accept = accept;
        state_next = state_reg;

        if (state_reg == ST_DUMP_RD)
        begin
            cmd.dump_read = 1'b1;
            state_next    = ST_DUMP_WR;
        end
        else if (state_reg == ST_DUMP_WR)
        begin
            if (sts.out_free)
            begin
                cmd.dump_emit = 1'b1;
                state_next    = sts.dump_last ? PH_CSEEK : ST_DUMP_RD;
            end
        end
        else if (accept && op)
        begin
            // end of stream
            cmd.emit_marker = (state_reg inside {[PH_CSEEK:PH_CREST]});
            cmd.restart     = 1'b1;
            cmd.end_clear   = 1'b1;
            state_next      = PH_SEEK;
        end
        else if (accept)
        begin
            case (state_reg)
                PH_OWS:
                begin
                    cmd.store = 1'b1;
                    if (!sts.is_space)
                    begin
                        cmd.open_name = 1'b1;
                        state_next    = PH_ONAME;
                    end
                end
                PH_ONAME, PH_OREST:
                begin
                    cmd.store = 1'b1;
                    if (state_reg == PH_ONAME && sts.is_alnum)
                    begin
                        cmd.open_name = 1'b1;
                    end
                    else if (sts.is_gt)
                    begin
                        if (sts.open_doc || sts.open_long)
                        begin
                            cmd.set_long   = 1'b1;
                            cmd.dump_start = 1'b1;
                            state_next     = ST_DUMP_RD;
                        end
                        else
                        begin
                            state_next = PH_SEEK;
                        end
                    end
                    else
                    begin
                        state_next = PH_OREST;
                    end
                end
                PH_CSEEK:
                begin
                    cmd.emit_in = 1'b1;
                    if (sts.is_lt)
                    begin
                        state_next = PH_CSLASH;
                    end
                end
                PH_CSLASH:
                begin
                    cmd.emit_in = 1'b1;
                    if (sts.is_slash)
                    begin
                        cmd.close_init = 1'b1;
                        state_next     = PH_CWS;
                    end
                    else if (!sts.is_space)
                    begin
                        state_next = PH_CSKIP;
                    end
                end
                PH_CSKIP:
                begin
                    cmd.emit_in = 1'b1;
                    if (sts.is_gt)
                    begin
                        state_next = PH_CSEEK;
                    end
                end
                PH_CWS:
                begin
                    cmd.emit_in = 1'b1;
                    if (!sts.is_space)
                    begin
                        cmd.close_name = 1'b1;
                        state_next     = PH_CNAME;
                    end
                end
                PH_CNAME, PH_CREST:
                begin
                    cmd.emit_in = 1'b1;
                    if (state_reg == PH_CNAME && sts.is_alnum)
                    begin
                        cmd.close_name = 1'b1;
                    end
                    else if (sts.is_gt)
                    begin
                        cmd.emit_last = sts.close_hit;
                        cmd.restart   = sts.close_hit;
                        state_next    = sts.close_hit ? PH_SEEK : PH_CSEEK;
                    end
                    else
                    begin
                        state_next = PH_CREST;
                    end
                end
                default:
                begin
                    state_next = PH_SEEK;
                    if (sts.is_lt)
                    begin
                        cmd.start_tag = 1'b1;
                        state_next    = PH_OWS;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_SEEK;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/doc_tag_stream_splitter.sv
// document splitter: one character transaction per cycle, results registered on acceptance
// a matching open tag stalls input while its n buffered characters are replayed from the
// tag buffer memory, each character by a registered read, then an output load
// throughput is otherwise limited only by the single output register and downstream ready
// rst_n is asynchronous, active low: parser back to bracket search, counters cleared
// depends on dts_pkg, dts_stream_if, dts_ctrl and dts_datapath
`default_nettype none

module doc_tag_stream_splitter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dts_in_if.sink      in_stream,
    dts_out_if.source   out_stream
);
    import dts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    dts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .op       (in_stream.op),
        .sts      (sts),
        .in_ready (in_stream.ready),
        .cmd      (cmd)
    );

    dts_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .in_char      (in_stream.in_char),
        .out_ready    (out_stream.ready),
        .sts          (sts),
        .out_valid    (out_stream.valid),
        .out_char     (out_stream.out_char),
        .char_valid   (out_stream.char_valid),
        .doc_offset   (out_stream.doc_offset),
        .first_of_doc (out_stream.first_of_doc),
        .last         (out_stream.last),
        .truncated    (out_stream.truncated),
        .tag_clipped  (out_stream.tag_clipped)
    );

endmodule

`default_nettype wire

// File: sv/dts_checker.sv
// port-level checks on the document splitter, bound to the top level
// depends on dts_stream_if and doc_tag_stream_splitter_macros.svh
`default_nettype none

`include "doc_tag_stream_splitter_macros.svh"

module dts_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dts_in_if.sink      in_stream,
    dts_out_if.source   out_stream
);

    `DTS_ASSERT_NEXT(a_out_valid_hold, clk, rst_n,
        out_stream.valid && !out_stream.ready, out_stream.valid,
        "result dropped while stalled")

    `DTS_ASSERT_IMP(a_stall_blocks_input, clk, rst_n,
        out_stream.valid && !out_stream.ready, !in_stream.ready,
        "input taken while result stalled")

    `DTS_ASSERT_IMP(a_marker_shape, clk, rst_n,
        out_stream.valid && !out_stream.char_valid,
        out_stream.last && out_stream.truncated && !out_stream.first_of_doc
            && (out_stream.out_char == '0),
        "malformed end marker")

    `DTS_ASSERT_IMP(a_first_shape, clk, rst_n,
        out_stream.valid && out_stream.first_of_doc,
        out_stream.char_valid && !out_stream.last && !out_stream.truncated,
        "malformed first transaction")

endmodule

bind doc_tag_stream_splitter dts_checker u_dts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_stream),
    .out_stream (out_stream)
);

`default_nettype wire
